FILE: hw/rtl/approx_float_power_unit_defines.svh
// assertion macros for the checker file
`ifndef APPROX_FLOAT_POWER_UNIT_DEFINES_SVH
`define APPROX_FLOAT_POWER_UNIT_DEFINES_SVH

// condition in the same cycle
`define AFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition in the following cycle
`define AFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/afp_pkg.sv
// constants and types of the approximate float power unit
package afp_pkg;

    localparam int FRAC_BITS = 23;
    localparam int NSTG      = 8;
    localparam int COEF_W    = 22;
    localparam int CORR_W    = 22;
    localparam int LMAG_W    = 31;
    localparam int MANT_W    = 24;
    localparam int PM_W      = 55;
    localparam int PMX_W     = 30;

    localparam logic [31:0] EPS_BITS    = 32'h3727C5AC;
    localparam logic [31:0] NEAR_ONE_LO = 32'h3F7FFF58;
    localparam logic [31:0] NEAR_ONE_HI = 32'h3F800054;
    localparam logic [31:0] BIAS_BITS   = 32'h3F800000;
    localparam logic [31:0] ONE_BITS    = 32'h3F800000;
    localparam logic [31:0] MAX_BITS    = 32'h7F7FFFFF;

    localparam logic [COEF_W-1:0] K_LOG = 22'd2907550;
    localparam logic [COEF_W-1:0] K_EXP = 22'd2849694;

    localparam logic [7:0]      EXP_INF   = 8'd255;
    localparam logic [7:0]      EXP_UNIT  = 8'd150;
    localparam logic [7:0]      SH_SAT    = 8'd40;
    localparam logic [PM_W-1:0] SAT_MAG   = PM_W'(1) << 40;
    localparam logic [PM_W-1:0] EPS_FX    = PM_W'(84);
    localparam logic [PM_W-1:0] LIMIT_FX  = PM_W'(64) << FRAC_BITS;

    typedef struct packed {
        logic sq_en;
        logic mul_en;
    } afp_qc_ctrl_t;

endpackage

FILE: hw/rtl/approx_float_power_unit.sv
// top level of the approximate float power unit
// Computes an approximate base^exponent on IEEE-754 single bit patterns with
// the log2/exp2 bit trick in fixed point. Fully pipelined: one request per
// cycle when the result side is ready. The eight register stages hold two
// quadratic corrections of two multiplies each, the log sum, the exponent
// multiply, the shift/saturate step and the result assembly. Each stage
// advances on its own, so bubbles close up and requests keep coming in
// while a finished result waits on res_ready, until every stage is full.
module approx_float_power_unit import afp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [31:0] base_bits,
    input  logic [31:0] exponent_bits,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [31:0] result_bits
);

    logic [NSTG-1:0] en;
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;

    // stage 0
    logic signed [32:0] l0_next;
    logic [32:0]        mg;
    logic               s0_zero_reg, s0_near_reg;
    logic signed [32:0] s0_l0_reg;
    logic [31:0]        s0_b_reg;
    // stage 1
    logic               s1_zero_reg, s1_near_reg;
    logic signed [32:0] s1_l0_reg;
    logic [31:0]        s1_b_reg;
    logic [CORR_W-1:0]  corr_log;
    // stage 2
    logic signed [33:0] lg;
    logic [33:0]        lg_abs;
    logic [7:0]         e_next;
    logic [MANT_W-1:0]  m_next;
    logic               s2_zero_reg, s2_neg_reg;
    logic [LMAG_W-1:0]  s2_lmag_reg;
    logic [7:0]         s2_e_reg;
    logic [MANT_W-1:0]  s2_m_reg;
    // stage 3
    logic               s3_zero_reg, s3_neg_reg, s3_lzero_reg;
    logic [7:0]         s3_e_reg;
    logic [PM_W-1:0]    s3_pm_raw_reg;
    // stage 4
    logic [7:0]         sh_up, sh_dn;
    logic [PM_W+38:0]   shl_wide;
    logic [PM_W-1:0]    pm_next;
    logic               s4_zero_reg, s4_neg_reg;
    logic [PM_W-1:0]    s4_pm_reg;
    // stage 5 and 6
    logic               s5_zero_reg, s5_neg_reg, s5_small_reg, s5_big_reg;
    logic [PMX_W-1:0]   s5_pm_reg;
    logic               s6_zero_reg, s6_neg_reg, s6_small_reg, s6_big_reg;
    logic [PMX_W-1:0]   s6_pm_reg;
    logic [CORR_W-1:0]  corr_exp;
    // stage 7
    logic signed [32:0] p_s;
    logic signed [32:0] x;
    logic [31:0]        result_next;
    logic [31:0]        result_reg;

    afp_qc_ctrl_t qc_log_ctrl, qc_exp_ctrl;

    // stall chain: a stage loads when it is empty or its successor loads
    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || res_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? req_valid : v_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign req_ready   = en[0];
    assign res_valid   = v_reg[NSTG-1];
    assign result_bits = result_reg;

    // log2 of the base
    assign l0_next = $signed({1'b0, base_bits}) - $signed({1'b0, BIAS_BITS});
    assign mg      = l0_next[32] ? 33'(-l0_next) : 33'(l0_next);

    assign qc_log_ctrl.sq_en  = en[0];
    assign qc_log_ctrl.mul_en = en[1];

    afp_quad_corr u_qc_log
    (
        .clk  (clk),
        .ctrl (qc_log_ctrl),
        .frac (mg[FRAC_BITS-1:0]),
        .coef (K_LOG),
        .corr (corr_log)
    );

    always_comb
    begin
        lg = s1_near_reg ? 34'sd0
                         : 34'(s1_l0_reg) + $signed({12'd0, corr_log});
        lg_abs = lg[33] ? 34'(-lg) : 34'(lg);
        if (s1_b_reg[30:23] == 8'd0)
        begin
            e_next = 8'd1;
            m_next = {1'b0, s1_b_reg[22:0]};
        end
        else
        begin
            e_next = s1_b_reg[30:23];
            m_next = {1'b1, s1_b_reg[22:0]};
        end
    end

    // scale the raw product by the exponent's power of two, saturating on overflow or an infinite exponent
    always_comb
    begin
        sh_up    = s3_e_reg - EXP_UNIT;
        sh_dn    = EXP_UNIT - s3_e_reg;
        shl_wide = {39'd0, s3_pm_raw_reg} << sh_up[5:0];
        if (s3_lzero_reg)
        begin
            pm_next = '0;
        end
        else if (s3_e_reg == EXP_INF)
        begin
            pm_next = SAT_MAG;
        end
        else if (s3_e_reg > EXP_UNIT)
        begin
            if (s3_pm_raw_reg != '0 &&
                (sh_up >= SH_SAT || shl_wide > {39'd0, SAT_MAG}))
            begin
                pm_next = SAT_MAG;
            end
            else
            begin
                pm_next = shl_wide[PM_W-1:0];
            end
        end
        else
        begin
            pm_next = s3_pm_raw_reg >> sh_dn;
        end
    end

    // exp2 of the product
    assign qc_exp_ctrl.sq_en  = en[5];
    assign qc_exp_ctrl.mul_en = en[6];

    afp_quad_corr u_qc_exp
    (
        .clk  (clk),
        .ctrl (qc_exp_ctrl),
        .frac (s4_pm_reg[FRAC_BITS-1:0]),
        .coef (K_EXP),
        .corr (corr_exp)
    );

    always_comb
    begin
        p_s = s6_neg_reg ? -$signed({3'd0, s6_pm_reg}) : $signed({3'd0, s6_pm_reg});
        x   = p_s + $signed({1'b0, BIAS_BITS}) - $signed({11'd0, corr_exp});
        if (s6_zero_reg)
        begin
            result_next = '0;
        end
        else if (s6_small_reg)
        begin
            result_next = ONE_BITS;
        end
        else if (s6_big_reg)
        begin
            result_next = s6_neg_reg ? 32'd0 : MAX_BITS;
        end
        else
        begin
            result_next = x[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_zero_reg <= base_bits[31] || base_bits <= EPS_BITS;
            s0_near_reg <= base_bits > NEAR_ONE_LO && base_bits < NEAR_ONE_HI;
            s0_l0_reg   <= l0_next;
            s0_b_reg    <= exponent_bits;
        end
        if (en[1])
        begin
            s1_zero_reg <= s0_zero_reg;
            s1_near_reg <= s0_near_reg;
            s1_l0_reg   <= s0_l0_reg;
            s1_b_reg    <= s0_b_reg;
        end
        if (en[2])
        begin
            s2_zero_reg <= s1_zero_reg;
            s2_neg_reg  <= s1_b_reg[31] ^ lg[33];
            s2_lmag_reg <= lg_abs[LMAG_W-1:0];
            s2_e_reg    <= e_next;
            s2_m_reg    <= m_next;
        end
        if (en[3])
        begin
            s3_zero_reg   <= s2_zero_reg;
            s3_neg_reg    <= s2_neg_reg;
            s3_lzero_reg  <= s2_lmag_reg == '0;
            s3_e_reg      <= s2_e_reg;
            s3_pm_raw_reg <= s2_m_reg * s2_lmag_reg;
        end
        if (en[4])
        begin
            s4_zero_reg <= s3_zero_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_pm_reg   <= pm_next;
        end
        if (en[5])
        begin
            s5_zero_reg  <= s4_zero_reg;
            s5_neg_reg   <= s4_neg_reg;
            s5_small_reg <= s4_pm_reg < EPS_FX;
            s5_big_reg   <= s4_pm_reg > LIMIT_FX;
            s5_pm_reg    <= s4_pm_reg[PMX_W-1:0];
        end
        if (en[6])
        begin
            s6_zero_reg  <= s5_zero_reg;
            s6_neg_reg   <= s5_neg_reg;
            s6_small_reg <= s5_small_reg;
            s6_big_reg   <= s5_big_reg;
            s6_pm_reg    <= s5_pm_reg;
        end
        if (en[7])
        begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: hw/rtl/afp_quad_corr.sv
// two-stage quadratic correction k * (f - f*f) on a 23-bit fraction
module afp_quad_corr import afp_pkg::*;
(
    input  logic                  clk,
    input  afp_qc_ctrl_t          ctrl,
    input  logic [FRAC_BITS-1:0]  frac,
    input  logic [COEF_W-1:0]     coef,
    output logic [CORR_W-1:0]     corr
);

    logic [FRAC_BITS-1:0]           frac_reg;
    logic [2*FRAC_BITS-1:0]         sq_reg;
    logic [FRAC_BITS+COEF_W-1:0]    prod_reg;
    logic [FRAC_BITS-1:0]           q;

    assign q    = frac_reg - sq_reg[2*FRAC_BITS-1:FRAC_BITS];
    assign corr = prod_reg[FRAC_BITS+COEF_W-1:FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (ctrl.sq_en)
        begin
            frac_reg <= frac;
            sq_reg   <= frac * frac;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= q * coef;
        end
    end

endmodule

FILE: hw/rtl/afp_checker.sv
// port-level checker for the approximate float power unit, bound to the top
`include "approx_float_power_unit_defines.svh"

module afp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] result_bits
);

    `AFP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
    `AFP_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(result_bits), "result changed while stalled")
    `AFP_ASSERT_NOW(a_full_only_on_stall, !req_ready, res_valid && !res_ready, "request refused without output stall")
    `AFP_ASSERT_NOW(a_result_positive, res_valid, !result_bits[31], "result has sign bit set")

endmodule

bind approx_float_power_unit afp_checker u_afp_checker (.*);

FILE: bench/approx_float_power_unit_test.sv
// testbench for approx_float_power_unit: streams base/exponent pairs and checks each result
module approx_float_power_unit_test;

    localparam logic [31:0] TINY_BASE     = 32'h3727C5AC;
    localparam logic [31:0] UNITY_LO      = 32'h3F7FFF58;
    localparam logic [31:0] UNITY_HI      = 32'h3F800054;
    localparam logic [31:0] ONE_PATTERN   = 32'h3F800000;
    localparam logic [31:0] MAX_PATTERN   = 32'h7F7FFFFF;
    localparam logic [63:0] LOG_COEF      = 64'd2907550;
    localparam logic [63:0] EXP_COEF      = 64'd2849694;
    localparam logic [63:0] FRAC_MASK23   = 64'h7FFFFF;
    localparam longint      BIAS_Q23      = longint'(127) << 23;
    localparam logic [63:0] PROD_FLOOR    = 64'd84;
    localparam logic [63:0] PROD_CEIL     = 64'd64 << 23;
    localparam logic [63:0] PROD_SAT      = 64'd1 << 40;
    localparam int unsigned EXP_ALL_ONES  = 255;
    localparam int          EXP_UNIT      = 150;
    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int          RANDOM_ITEMS  = 700;

    typedef struct {
        logic [31:0] base;
        logic [31:0] expo;
        logic [31:0] result;
    } power_case_t;

    typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    class power_scoreboard;
        power_case_t expected_q[$];
        int errors = 0;

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function logic [63:0] fraction_bend(logic [63:0] frac, logic [63:0] coef);
            logic [63:0] q;
            q = frac - ((frac * frac) >> 23);
            return (q * coef) >> 23;
        endfunction

        function logic [31:0] predict_power(logic [31:0] base, logic [31:0] expo);
            longint      lin, log_fx, p, x;
            logic [63:0] lin_mag, log_mag, prod, mant;
            int unsigned ex;
            int          sh;
            logic        neg;
            if (base[31] || base <= TINY_BASE)
                return 32'h0;
            if (base > UNITY_LO && base < UNITY_HI)
                log_fx = 0;
            else
            begin
                lin = longint'({32'h0, base}) - BIAS_Q23;
                lin_mag = (lin < 0) ? -lin : lin;
                log_fx = lin + longint'(fraction_bend(lin_mag & FRAC_MASK23, LOG_COEF));
            end
            log_mag = (log_fx < 0) ? -log_fx : log_fx;
            neg = expo[31] ^ (log_fx < 0);
            ex = expo[30:23];
            mant = {41'h0, expo[22:0]};
            if (ex == 0)
                ex = 1;
            else
                mant[23] = 1'b1;
            if (log_mag == 0)
                prod = 64'h0;
            else if (ex == EXP_ALL_ONES)
                prod = PROD_SAT;
            else
            begin
                sh = int'(ex) - EXP_UNIT;
                prod = mant * log_mag;
                if (sh > 0)
                begin
                    if (prod != 0 && (sh >= 40 || prod > (PROD_SAT >> sh)))
                        prod = PROD_SAT;
                    else
                        prod = prod << sh;
                end
                else
                    prod = (-sh >= 63) ? 64'h0 : (prod >> (-sh));
            end
            if (prod < PROD_FLOOR)
                return ONE_PATTERN;
            if (prod > PROD_CEIL)
                return neg ? 32'h0 : MAX_PATTERN;
            p = neg ? -longint'(prod) : longint'(prod);
            x = p + BIAS_Q23 - longint'(fraction_bend(prod & FRAC_MASK23, EXP_COEF));
            return x[31:0];
        endfunction

        function void note_request(logic [31:0] base, logic [31:0] expo);
            power_case_t c;
            c.base = base;
            c.expo = expo;
            c.result = predict_power(base, expo);
            expected_q.push_back(c);
        endfunction

        task check_result(logic [31:0] got);
            power_case_t c;
            if (expected_q.size() == 0)
                report($sformatf("result %h with no request outstanding", got));
            else
            begin
                c = expected_q.pop_front();
                if (got !== c.result)
                    report($sformatf("base %h exponent %h: result %h, expected %h",
                        c.base, c.expo, got, c.result));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        res_ready = 1'b0;
    logic [31:0] base_bits;
    logic [31:0] exponent_bits;
    logic        req_ready;
    logic        res_valid;
    logic [31:0] result_bits;

    power_scoreboard sb = new;
    int unsigned     cycle_count = 0;
    int              burst_left = 0;
    rx_mode_t        rx_mode = RX_OPEN;
    int              rx_left = 0;
    int unsigned     rx_tick = 0;

    approx_float_power_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .base_bits     (base_bits),
        .exponent_bits (exponent_bits),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .result_bits   (result_bits)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("approx_float_power_unit_test: errors");
            $finish;
        end
    end

    // result side: check, then pick the next ready pattern
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(result_bits);
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 150);
        end
        else
            rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:     res_ready <= 1'b1;
            RX_MOSTLY:   res_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE:   res_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: res_ready <= ((rx_tick % 13) < 4);
            default:     res_ready <= 1'b1;
        endcase
    end

    task automatic send_request(input logic [31:0] b, input logic [31:0] e);
        int gap;
        req_valid <= 1'b1;
        base_bits <= b;
        exponent_bits <= e;
        do @(posedge clk); while (!req_ready);
        sb.note_request(b, e);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] b, e;
        int          pick;
        rst_n = 1'b0;
        req_valid = 1'b0;
        base_bits = 32'h0;
        exponent_bits = 32'h0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, negative and tiny bases
        send_request(32'h00000000, 32'h40000000);
        send_request(32'h80000000, 32'h40000000);
        send_request(32'hBF800000, 32'h3F800000);
        send_request(32'h3727C5AC, 32'h3F800000);
        send_request(32'h3727C5AD, 32'h3F800000);
        // window around one
        send_request(32'h3F7FFF58, 32'h40400000);
        send_request(32'h3F7FFF59, 32'h7F800000);
        send_request(32'h3F800053, 32'h7FC00000);
        send_request(32'h3F800054, 32'h7F7FFFFF);
        // infinite and extreme bases
        send_request(32'h7F800000, 32'h3F000000);
        send_request(32'h7FFFFFFF, 32'h00000001);
        // tiny product, product at and beyond +-64, saturation
        send_request(32'h40000000, 32'h00000000);
        send_request(32'h40000000, 32'h80000000);
        send_request(32'h40000000, 32'h37280000);
        send_request(32'h40000000, 32'h3727FFFF);
        send_request(32'h40000000, 32'h42800000);
        send_request(32'h40000000, 32'hC2800000);
        send_request(32'h40000000, 32'h42800001);
        send_request(32'h40000000, 32'hC2800001);
        send_request(32'h40000000, 32'h7F000000);
        // negative log, infinite exponents
        send_request(32'h3F000000, 32'h40400000);
        send_request(32'h3F000000, 32'hFF800000);
        send_request(32'h40490FDB, 32'hBFC00000);
        send_request(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_request(32'h3F7FFFFF, 32'h4B000000);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1:
                begin
                    b = $urandom();
                    e = $urandom();
                end
                6:
                begin
                    b = 32'h3F7FFF00 + $urandom_range(0, 32'h1A0);
                    e = $urandom();
                end
                7:
                begin
                    b = {1'b0, 8'($urandom_range(100, 160)), 23'($urandom())};
                    e = {1'($urandom()), ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                        23'($urandom())};
                end
                8:
                begin
                    b = TINY_BASE - 2 + $urandom_range(0, 4);
                    b[31] = ($urandom_range(0, 3) == 0);
                    e = {1'($urandom()), 8'($urandom_range(110, 135)), 23'($urandom())};
                end
                9:
                begin
                    b = 32'h40000000;
                    case ($urandom_range(0, 2))
                        0: e = {1'($urandom()), 8'd133, 23'($urandom_range(0, 2))};
                        1: e = {1'($urandom()), 8'd132, 23'h7FFFFF};
                        default: e = {1'($urandom()), 8'd110,
                            23'h27FFF0 + 23'($urandom_range(0, 31))};
                    endcase
                end
                default:
                begin
                    b = {1'b0, 8'($urandom_range(100, 160)), 23'($urandom())};
                    e = {1'($urandom()), 8'($urandom_range(110, 135)), 23'($urandom())};
                end
            endcase
            send_request(b, e);
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("approx_float_power_unit_test: clean");
        else
            $display("approx_float_power_unit_test: errors");
        $finish;
    end

endmodule
